### rtl/core/abre_pkg.sv
package abre_pkg;

  localparam int unsigned CONTEXTS     = 4096;
  localparam int unsigned CTX_W        = $clog2(CONTEXTS);
  localparam int unsigned PROB_BITS    = 11;
  localparam int unsigned ADAPT_SHIFT  = 5;
  localparam int unsigned NORM_MAX     = 4;
  localparam int unsigned FLUSH_SHIFTS = 5;
  localparam int unsigned MAX_RESULTS  = 6;
  localparam int unsigned MAX_DIRECT   = 30;
  localparam int unsigned K_W          = $clog2(NORM_MAX + 1);
  localparam int unsigned FC_W         = $clog2(FLUSH_SHIFTS + 1);
  localparam int unsigned EM_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [PROB_BITS-1:0] PROB_INIT = PROB_BITS'(1024);
  localparam logic [31:0] TOP_LIMIT   = 32'h0100_0000;
  localparam logic [31:0] SHIFT_LIMIT = 32'hff00_0000;
  localparam logic [31:0] RANGE_INIT  = 32'hffff_ffff;
  localparam logic [31:0] PEND_MAX    = 32'hffff_ffff;
  localparam logic [7:0]  FILL_BASE   = 8'hff;

  typedef enum logic [1:0] {
    OP_BIT    = 2'd0,
    OP_DIRECT = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_BEGIN  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROB,
    ST_CODE,
    ST_DBIT,
    ST_NORM,
    ST_FLUSH,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] context_req;
    logic        bit_value;
    logic [29:0] direct_value;
    logic [4:0]  direct_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  lead_byte;
    logic [7:0]  fill_byte;
    logic [31:0] fill_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic prob;
    logic code;
    logic dbit;
    logic shift;
    logic shift_range;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic norm_more;
    logic bits_left;
    logic flush_more;
    logic shift_ok;
    logic direct_mode;
  } ctrl_status_t;

  function automatic logic [CTX_W-1:0] ctx_index(input logic [11:0] ctx);
    logic [CTX_W+11:0] ext;
    ext = {{CTX_W{1'b0}}, ctx};
    return ext[CTX_W-1:0];
  endfunction

endpackage

### rtl/core/abre_ram.sv
module abre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/abre_ctrl.sv
module abre_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  abre_pkg::op_e          in_op_i,
  input  abre_pkg::ctrl_status_t status_i,
  output logic                   in_ready_o,
  output abre_pkg::ctrl_cmd_t    cmd_o
);

  abre_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abre_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      abre_pkg::ST_CLEAR: begin
        if (status_i.clear_last) state_d = abre_pkg::ST_IDLE;
      end
      abre_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            abre_pkg::OP_BIT:    state_d = abre_pkg::ST_PROB;
            abre_pkg::OP_DIRECT: state_d = abre_pkg::ST_DBIT;
            abre_pkg::OP_FLUSH:  state_d = abre_pkg::ST_FLUSH;
            abre_pkg::OP_BEGIN:  state_d = abre_pkg::ST_CLEAR;
            default:             state_d = abre_pkg::ST_IDLE;
          endcase
        end
      end
      abre_pkg::ST_PROB: state_d = abre_pkg::ST_CODE;
      abre_pkg::ST_CODE: state_d = abre_pkg::ST_NORM;
      abre_pkg::ST_DBIT: begin
        state_d = status_i.bits_left ? abre_pkg::ST_NORM : abre_pkg::ST_FIN;
      end
      abre_pkg::ST_NORM: begin
        if (!status_i.norm_more) begin
          state_d = status_i.direct_mode ? abre_pkg::ST_DBIT : abre_pkg::ST_FIN;
        end
      end
      abre_pkg::ST_FLUSH: begin
        if (!status_i.flush_more) state_d = abre_pkg::ST_FIN;
      end
      abre_pkg::ST_FIN: begin
        if (status_i.shift_ok) state_d = abre_pkg::ST_IDLE;
      end
      default: state_d = abre_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      abre_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      abre_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      abre_pkg::ST_PROB: cmd_o.prob = 1'b1;
      abre_pkg::ST_CODE: cmd_o.code = 1'b1;
      abre_pkg::ST_DBIT: cmd_o.dbit = status_i.bits_left;
      abre_pkg::ST_NORM: begin
        cmd_o.shift       = status_i.norm_more && status_i.shift_ok;
        cmd_o.shift_range = 1'b1;
      end
      abre_pkg::ST_FLUSH: cmd_o.shift = status_i.flush_more && status_i.shift_ok;
      abre_pkg::ST_FIN:   cmd_o.fin = status_i.shift_ok;
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/core/abre_datapath.sv
module abre_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  abre_pkg::in_item_t     in_item_i,
  input  abre_pkg::ctrl_cmd_t    cmd_i,
  output abre_pkg::ctrl_status_t status_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output abre_pkg::out_item_t    out_item_o
);

  localparam int unsigned PB = abre_pkg::PROB_BITS;
  localparam int unsigned CW = abre_pkg::CTX_W;

  // coder state
  logic [32:0] low_q, low_d;
  logic [31:0] range_q, range_d;
  logic [7:0]  cache_q, cache_d;
  logic [31:0] pend_q, pend_d;

  // sequencing
  abre_pkg::op_e               op_q, op_d;
  logic [4:0]                  dcnt_q, dcnt_d;
  logic [abre_pkg::K_W-1:0]    k_q, k_d;
  logic [abre_pkg::FC_W-1:0]   fcnt_q, fcnt_d;
  logic [abre_pkg::EM_W-1:0]   emit_q, emit_d;
  logic [CW-1:0]               clr_addr_q, clr_addr_d;
  logic                        hold_valid_q, hold_valid_d;
  logic                        out_valid_q, out_valid_d;

  // payload
  logic [CW-1:0]       ctx_q, ctx_d;
  logic                bit_q, bit_d;
  logic [29:0]         dval_q, dval_d;
  logic [31:0]         bound_q, bound_d;
  abre_pkg::out_item_t hold_q, hold_d;
  abre_pkg::out_item_t out_q, out_d;

  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [PB-1:0] ram_wdata;
  logic [PB-1:0] ram_rdata;

  logic [PB:0]         up_gap;
  logic [PB-1:0]       prob_up, prob_dn;
  logic [31:0]         product;
  logic [31:0]         half;
  logic [4:0]          bidx;
  logic [31:0]         lo32;
  logic                carry, rel, emit, out_free;
  abre_pkg::out_item_t res;

  abre_ram #(
    .WIDTH(PB),
    .DEPTH(abre_pkg::CONTEXTS)
  ) u_prob_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(abre_pkg::ctx_index(in_item_i.context_req)),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    up_gap  = {1'b1, {PB{1'b0}}} - {1'b0, ram_rdata};
    prob_up = ram_rdata + PB'(up_gap >> abre_pkg::ADAPT_SHIFT);
    prob_dn = ram_rdata - (ram_rdata >> abre_pkg::ADAPT_SHIFT);
    product = {{PB{1'b0}}, range_q[31:PB]} * {{(32 - PB){1'b0}}, ram_rdata};
    half    = {1'b0, range_q[31:1]};
    bidx    = 5'(dcnt_q - 5'd1);
    lo32    = low_q[31:0];
    carry   = low_q[32];
    rel     = (lo32 < abre_pkg::SHIFT_LIMIT) || carry;
    emit    = rel && (emit_q < abre_pkg::EM_W'(abre_pkg::MAX_RESULTS));
    res.lead_byte  = cache_q + {7'd0, carry};
    res.fill_byte  = abre_pkg::FILL_BASE + {7'd0, carry};
    res.fill_count = pend_q - 32'd1;
    res.last       = 1'b0;
    out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    low_d        = low_q;
    range_d      = range_q;
    cache_d      = cache_q;
    pend_d       = pend_q;
    op_d         = op_q;
    dcnt_d       = dcnt_q;
    k_d          = k_q;
    fcnt_d       = fcnt_q;
    emit_d       = emit_q;
    clr_addr_d   = clr_addr_q;
    hold_valid_d = hold_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ctx_d        = ctx_q;
    bit_d        = bit_q;
    dval_d       = dval_q;
    bound_d      = bound_q;
    hold_d       = hold_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_q;
    ram_wdata    = abre_pkg::PROB_INIT;

    if (cmd_i.accept) begin
      op_d   = abre_pkg::op_e'(in_item_i.op);
      ctx_d  = abre_pkg::ctx_index(in_item_i.context_req);
      bit_d  = in_item_i.bit_value;
      dval_d = in_item_i.direct_value;
      dcnt_d = (in_item_i.direct_count > 5'(abre_pkg::MAX_DIRECT)) ?
               5'(abre_pkg::MAX_DIRECT) : in_item_i.direct_count;
      fcnt_d = '0;
      emit_d = '0;
      if (abre_pkg::op_e'(in_item_i.op) == abre_pkg::OP_BEGIN) begin
        low_d      = '0;
        range_d    = abre_pkg::RANGE_INIT;
        cache_d    = '0;
        pend_d     = 32'd1;
        clr_addr_d = '0;
      end
    end

    if (cmd_i.clear) begin
      ram_we     = 1'b1;
      clr_addr_d = clr_addr_q + CW'(1);
    end

    if (cmd_i.prob) begin
      ram_we    = 1'b1;
      ram_waddr = ctx_q;
      ram_wdata = bit_q ? prob_dn : prob_up;
      bound_d   = product;
    end

    if (cmd_i.code) begin
      k_d = '0;
      if (!bit_q) begin
        range_d = bound_q;
      end else begin
        low_d   = low_q + {1'b0, bound_q};
        range_d = range_q - bound_q;
      end
    end

    if (cmd_i.dbit) begin
      k_d     = '0;
      range_d = half;
      dcnt_d  = bidx;
      if (dval_q[bidx]) low_d = low_q + {1'b0, half};
    end

    if (cmd_i.shift) begin
      if (rel) begin
        cache_d = lo32[31:24];
        pend_d  = 32'd1;
      end else if (pend_q != abre_pkg::PEND_MAX) begin
        pend_d = pend_q + 32'd1;
      end
      low_d = {1'b0, lo32[23:0], 8'h00};
      if (cmd_i.shift_range) begin
        range_d = {range_q[23:0], 8'h00};
        k_d     = k_q + abre_pkg::K_W'(1);
      end else begin
        fcnt_d = fcnt_q + abre_pkg::FC_W'(1);
      end
      if (emit) begin
        emit_d = emit_q + abre_pkg::EM_W'(1);
        if (hold_valid_q) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
        end
        hold_d       = res;
        hold_valid_d = 1'b1;
      end
    end

    if (cmd_i.fin && hold_valid_q) begin
      out_d        = hold_q;
      out_d.last   = 1'b1;
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q        <= '0;
      range_q      <= abre_pkg::RANGE_INIT;
      cache_q      <= '0;
      pend_q       <= 32'd1;
      op_q         <= abre_pkg::OP_BIT;
      dcnt_q       <= '0;
      k_q          <= '0;
      fcnt_q       <= '0;
      emit_q       <= '0;
      clr_addr_q   <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      low_q        <= low_d;
      range_q      <= range_d;
      cache_q      <= cache_d;
      pend_q       <= pend_d;
      op_q         <= op_d;
      dcnt_q       <= dcnt_d;
      k_q          <= k_d;
      fcnt_q       <= fcnt_d;
      emit_q       <= emit_d;
      clr_addr_q   <= clr_addr_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q   <= ctx_d;
    bit_q   <= bit_d;
    dval_q  <= dval_d;
    bound_q <= bound_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  always_comb begin
    status_o.clear_last  = (clr_addr_q == CW'(abre_pkg::CONTEXTS - 1));
    status_o.norm_more   = (range_q < abre_pkg::TOP_LIMIT) &&
                           (k_q < abre_pkg::K_W'(abre_pkg::NORM_MAX));
    status_o.bits_left   = (dcnt_q != 5'd0);
    status_o.flush_more  = (fcnt_q < abre_pkg::FC_W'(abre_pkg::FLUSH_SHIFTS));
    status_o.shift_ok    = !hold_valid_q || out_free;
    status_o.direct_mode = (op_q == abre_pkg::OP_DIRECT);
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/core/adaptive_binary_range_encoder.sv
// Items are taken one at a time, and a stalled result output holds the encoder back:
//   adaptive bit: table read, multiply, update, then renormalising byte shifts.
//   direct bits:  one interval halving per bit, each followed by byte shifts; flush: five byte shifts.
//   begin block: the probability RAM is swept, all 4096 entries set to 1024.
// Reset is asynchronous, active low; the sweep then runs, and no item is accepted until it ends.
module adaptive_binary_range_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  abre_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output abre_pkg::out_item_t out_item_o
);

  abre_pkg::ctrl_cmd_t    cmd;
  abre_pkg::ctrl_status_t status;

  abre_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (abre_pkg::op_e'(in_item_i.op)),
    .status_i  (status),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  abre_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

### rtl/core/abre_checker.sv
module abre_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input abre_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input abre_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  a_begin_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.op == abre_pkg::OP_BEGIN |=> ##1 !in_ready_o)
    else $error("begin block skipped table sweep");

  a_pend_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.fill_count != 32'hffff_ffff)
    else $error("fill count beyond saturation");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_item_o.last)
    else $error("idle with non-final result pending");

endmodule

bind adaptive_binary_range_encoder abre_checker u_abre_checker (.*);

### dv/adaptive_binary_range_encoder_tb.sv
`timescale 1ns / 100ps

import abre_pkg::*;

class encoder_scoreboard;
  bit [32:0]          acc;
  bit [31:0]          rng;
  bit [7:0]           cache;
  bit [31:0]          pend;
  bit [PROB_BITS-1:0] prob_q [CONTEXTS];
  out_item_t          due_q [$];
  int unsigned        batch_n;
  int unsigned        errors;
  int unsigned        checked;
  int unsigned        carries;
  int unsigned        longest_fill;
  int unsigned        op_seen [4];

  function new();
    restart();
  endfunction

  function void restart();
    acc   = '0;
    rng   = RANGE_INIT;
    cache = '0;
    pend  = 32'd1;
    foreach (prob_q[i]) prob_q[i] = PROB_INIT;
  endfunction

  function void shift_byte();
    bit [31:0] lo32;
    bit        c;
    out_item_t r;
    lo32 = acc[31:0];
    c    = acc[32];
    if (lo32 < SHIFT_LIMIT || c) begin
      if (batch_n < MAX_RESULTS) begin
        r.lead_byte  = cache + 8'(c);
        r.fill_byte  = FILL_BASE + 8'(c);
        r.fill_count = pend - 32'd1;
        r.last       = 1'b0;
        due_q.push_back(r);
        batch_n++;
      end
      cache = lo32[31:24];
      pend  = 32'd1;
    end else if (pend != PEND_MAX) begin
      pend++;
    end
    acc = {1'b0, lo32[23:0], 8'h00};
  endfunction

  function void renorm();
    int unsigned k;
    for (k = 0; k < NORM_MAX && rng < TOP_LIMIT; k++) begin
      rng = rng << 8;
      shift_byte();
    end
  endfunction

  function void note_item(in_item_t it);
    int unsigned ctx;
    int unsigned pv;
    int unsigned cnt;
    int unsigned i;
    int unsigned first;
    bit [31:0]   bound;
    first   = due_q.size();
    batch_n = 0;
    op_seen[it.op]++;
    case (op_e'(it.op))
      OP_BIT: begin
        ctx   = it.context_req % CONTEXTS;
        pv    = prob_q[ctx];
        bound = (rng >> PROB_BITS) * pv;
        if (!it.bit_value) begin
          rng = bound;
          pv  = pv + (((1 << PROB_BITS) - pv) >> ADAPT_SHIFT);
        end else begin
          acc = acc + bound;
          rng = rng - bound;
          pv  = pv - (pv >> ADAPT_SHIFT);
        end
        prob_q[ctx] = pv[PROB_BITS-1:0];
        renorm();
      end
      OP_DIRECT: begin
        cnt = it.direct_count;
        if (cnt > MAX_DIRECT) cnt = MAX_DIRECT;
        for (i = cnt; i > 0; i--) begin
          rng = rng >> 1;
          if (it.direct_value[i-1]) acc = acc + rng;
          renorm();
        end
      end
      OP_FLUSH: begin
        repeat (FLUSH_SHIFTS) shift_byte();
      end
      default: begin
        restart();
      end
    endcase
    if (due_q.size() > first) due_q[due_q.size()-1].last = 1'b1;
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    checked++;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result %0d with none pending: lead %h fill %h x%0d last %b",
                 checked, got.lead_byte, got.fill_byte, got.fill_count, got.last);
      return;
    end
    want = due_q.pop_front();
    if (want.fill_byte == 8'h00) carries++;
    if (want.fill_count > longest_fill) longest_fill = want.fill_count;
    if (got.lead_byte !== want.lead_byte || got.fill_byte !== want.fill_byte ||
        got.fill_count !== want.fill_count || got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: want lead %h fill %h x%0d last %b, got lead %h fill %h x%0d last %b",
                 checked, want.lead_byte, want.fill_byte, want.fill_count, want.last,
                 got.lead_byte, got.fill_byte, got.fill_count, got.last);
    end
  endfunction

  function int unsigned outstanding();
    return due_q.size();
  endfunction

  function int unsigned failures();
    return errors + due_q.size();
  endfunction
endclass

module adaptive_binary_range_encoder_tb;

  localparam int unsigned RANDOM_ITEMS = 256;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned MAX_WAIT     = 17;
  localparam int unsigned IN_W         = $bits(in_item_t);

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  encoder_scoreboard sb;
  int unsigned       sent      = 0;
  int unsigned       cycle_cnt = 0;

  adaptive_binary_range_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_item(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
    end
  end

  // result side: random stall per item, with stall-free stretches
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = (taken % 50 < 12) ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  function automatic in_item_t mk(op_e op, int unsigned ctx, bit b,
                                  int unsigned val, int unsigned cnt);
    in_item_t it;
    it              = '0;
    it.op           = op;
    it.context_req  = 12'(ctx);
    it.bit_value    = b;
    it.direct_value = 30'(val);
    it.direct_count = 5'(cnt);
    return it;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i); while (sb.outstanding() != 0);
    @(posedge clk_i);
  endtask

  task automatic send_item(input in_item_t it, input bit drain);
    int unsigned gap;
    gap = (sent % 64 < 16) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0 || drain) in_valid_i <= 1'b0;
    if (drain) wait_drained();
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  initial begin
    in_item_t    it;
    int unsigned i;
    int unsigned sel;
    int unsigned hot;
    int unsigned skew;
    sb   = new();
    hot  = 0;
    skew = 50;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(mk(OP_BIT, 0, 1'b0, 0, 0), 1'b0);
    send_item(mk(OP_BIT, 4095, 1'b1, 0, 0), 1'b0);
    send_item(mk(OP_BIT, 12'haaa, 1'b0, 0, 0), 1'b0);
    send_item(mk(OP_BIT, 12'h555, 1'b1, 0, 0), 1'b0);
    send_item(mk(OP_DIRECT, 0, 1'b0, 30'h3fffffff, 0), 1'b0);
    send_item(mk(OP_DIRECT, 0, 1'b0, 1, 1), 1'b0);
    send_item(mk(OP_DIRECT, 0, 1'b0, 30'h3fffffff, 30), 1'b0);
    send_item(mk(OP_DIRECT, 0, 1'b0, 30'h2aaaaaaa, 31), 1'b0);  // count saturates
    send_item(mk(OP_DIRECT, 0, 1'b0, 0, 30), 1'b0);
    send_item(mk(OP_FLUSH, 0, 1'b0, 0, 0), 1'b0);
    send_item(mk(OP_FLUSH, 0, 1'b0, 0, 0), 1'b0);
    send_item(mk(OP_BEGIN, 0, 1'b0, 0, 0), 1'b0);
    // all-ones direct bits build a long run of 0xff bytes
    repeat (3) send_item(mk(OP_DIRECT, 0, 1'b0, 30'h3fffffff, 30), 1'b0);
    send_item(mk(OP_FLUSH, 0, 1'b0, 0, 0), 1'b0);
    repeat (8) send_item(mk(OP_BIT, 7, 1'b0, 0, 0), 1'b0);
    send_item(mk(OP_BIT, 7, 1'b1, 0, 0), 1'b0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 48 == 0) begin
        hot  = $urandom_range(0, 511);
        skew = $urandom_range(3, 97);
      end
      sel = $urandom_range(0, 99);
      it  = in_item_t'(IN_W'({$urandom, $urandom}));
      if (sel < 62) begin
        it.op        = OP_BIT;
        if ($urandom_range(0, 9) != 0)
          it.context_req = {hot[8:0], 3'($urandom_range(0, 7))};
        it.bit_value = ($urandom_range(0, 99) >= skew);
      end else if (sel < 80) begin
        it.op = OP_DIRECT;
        case ($urandom_range(0, 3))
          0: it.direct_value = '1;
          1: it.direct_value = '0;
          default: ;
        endcase
      end else if (sel < 92) begin
        it.op = OP_FLUSH;
      end else if (sel < 95) begin
        it.op = OP_BEGIN;
      end
      send_item(it, i == RANDOM_ITEMS / 2);
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (64) @(posedge clk_i);

    $display("Sent %0d adaptive bits, %0d direct-bit items, %0d flushes, %0d block starts",
             sb.op_seen[OP_BIT], sb.op_seen[OP_DIRECT], sb.op_seen[OP_FLUSH],
             sb.op_seen[OP_BEGIN]);
    $display("Checked %0d byte groups, %0d with carry, longest fill run %0d",
             sb.checked, sb.carries, sb.longest_fill);
    if (sb.failures() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/abre_pkg.sv
rtl/core/abre_ram.sv
rtl/core/abre_ctrl.sv
rtl/core/abre_datapath.sv
rtl/core/adaptive_binary_range_encoder.sv
rtl/core/abre_checker.sv
dv/adaptive_binary_range_encoder_tb.sv
